// File: rtl/core/duplicate_packet_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Duplicate packet filter assertion macros
// Shared property shorthands for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_PACKET_FILTER_TOP_MACROS_SVH
`define DUPLICATE_PACKET_FILTER_TOP_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define DPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpf property violated");

// Next-cycle implication, ignored while in reset.
`define DPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpf property violated");

// Next-cycle implication that also covers reset itself.
`define DPF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpf reset property violated");

`endif

// File: rtl/core/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Types and constants shared by the duplicate packet filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpf_pkg;

  localparam int ID_W      = 32;
  localparam int LIFE_W    = 32;
  localparam int SLOT_W    = 8;
  localparam int LIVE_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES  = 2'd1;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [LIFE_W-1:0] LIFETIME_RST = 32'd60000;
  localparam logic [LIVE_W-1:0] ENTRIES_RST  = 9'd256;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/dpf_entry_ram.sv
// ----------------------------------------------------------------------------
// dpf_entry_ram
// Entry table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_entry_ram import dpf_pkg::*; #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 113
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/duplicate_packet_filter_top.sv
// Check item: the scan reads the first n slots, n = configured entry count
//   clamped to 1..TABLE_DEPTH (one memory read per slot, single read port).
// A tick item gives no result. One item is in work at a time.
// Reset: synchronous, active low; afterwards a clearing pass writes every
//   entry invalid before the first item is accepted.
// ----------------------------------------------------------------------------
// duplicate_packet_filter_top
// Duplicate packet filter: time-limited cache of (origin, sequence) pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module duplicate_packet_filter_top import dpf_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int TIME_WIDTH  = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // check / tick items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [ID_W-1:0]      in_origin,
  input  wire logic [ID_W-1:0]      in_sequence_number,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_is_new,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [LIVE_W-1:0]         out_live_entries,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 1 + 2 * ID_W + TIME_WIDTH;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic                  valid;
    logic [ID_W-1:0]       origin;
    logic [ID_W-1:0]       seq_num;
    logic [TIME_WIDTH-1:0] expiry;
  } entry_t;

  // control state
  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]     ptr_r, ptr_nxt;
  logic [TIME_WIDTH-1:0] time_r, time_nxt;
  logic [LIFE_W-1:0]     lifetime_r, lifetime_nxt;
  logic [LIVE_W-1:0]     entries_r, entries_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [CNT_W-1:0]      scan_addr_r, scan_addr_nxt;

  // per-item working registers
  logic [ID_W-1:0]       org_r, org_nxt;
  logic [ID_W-1:0]       seq_r, seq_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [TIME_WIDTH-1:0] exp_r, exp_nxt;
  logic [ADDR_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                  match_found_r, match_found_nxt;
  logic [ADDR_W-1:0]     match_slot_r, match_slot_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [ADDR_W-1:0]     free_slot_r, free_slot_nxt;
  logic [CNT_W-1:0]      live_cnt_r, live_cnt_nxt;
  logic                  out_is_new_r, out_is_new_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [LIVE_W-1:0]     out_live_r, out_live_nxt;

  // memory port
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  entry_t                mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  entry_t                rd_entry;

  // helpers
  logic                  in_fire;
  logic                  out_free;
  logic [CNT_W-1:0]      n_cfg;
  logic [LIFE_W-1:0]     life_eff;
  logic [TIME_WIDTH:0]   exp_sum;
  logic                  rd_live;
  logic                  rd_match;
  logic                  new_live;
  logic [ADDR_W-1:0]     fin_slot;
  logic [CNT_W-1:0]      fin_live;
  logic [CNT_W-1:0]      slot_inc;

  dpf_entry_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_is_new       = out_is_new_r;
  assign out_slot         = out_slot_r;
  assign out_live_entries = out_live_r;

  // slot count clamped to 1..TABLE_DEPTH
  always_comb begin
    if (entries_r == '0) begin
      n_cfg = CNT_W'(1);
    end else if (32'(entries_r) > 32'(TABLE_DEPTH)) begin
      n_cfg = CNT_W'(TABLE_DEPTH);
    end else begin
      n_cfg = CNT_W'(entries_r);
    end
  end

  // saturating expiry: overflow shows as the carry out
  assign life_eff = (lifetime_r == '0) ? LIFE_W'(1) : lifetime_r;
  assign exp_sum  = {1'b0, time_r} + (TIME_WIDTH + 1)'(life_eff);

  assign rd_live  = rd_entry.valid && (rd_entry.expiry > time_r);
  assign rd_match = rd_live && (rd_entry.origin == org_r) && (rd_entry.seq_num == seq_r);
  assign new_live = (time_r != TIME_MAX);

  // final slot and live count, taken from the scan results
  always_comb begin
    if (match_found_r) begin
      fin_slot = match_slot_r;
      fin_live = live_cnt_r;
    end else begin
      if (free_found_r) begin
        fin_slot = free_slot_r;
      end else if (CNT_W'(ptr_r) < n_r) begin
        fin_slot = ptr_r;
      end else begin
        fin_slot = '0;
      end
      // replacing a live slot drops one live entry
      fin_live = live_cnt_r + CNT_W'(new_live) - CNT_W'(!free_found_r);
    end
    slot_inc = CNT_W'(fin_slot) + CNT_W'(1);
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    ptr_nxt         = ptr_r;
    time_nxt        = time_r;
    lifetime_nxt    = lifetime_r;
    entries_nxt     = entries_r;
    out_valid_nxt   = out_valid_r;
    rd_pend_nxt     = 1'b0;
    scan_addr_nxt   = scan_addr_r;
    org_nxt         = org_r;
    seq_nxt         = seq_r;
    n_nxt           = n_r;
    exp_nxt         = exp_r;
    rd_idx_nxt      = rd_idx_r;
    match_found_nxt = match_found_r;
    match_slot_nxt  = match_slot_r;
    free_found_nxt  = free_found_r;
    free_slot_nxt   = free_slot_r;
    live_cnt_nxt    = live_cnt_r;
    out_is_new_nxt  = out_is_new_r;
    out_slot_nxt    = out_slot_r;
    out_live_nxt    = out_live_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_addr_r;
    mem_wdata       = '0;
    mem_raddr       = scan_addr_r[ADDR_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIFETIME: lifetime_nxt = cfg_wdata[LIFE_W-1:0];
        CFG_ENTRIES:  entries_nxt  = cfg_wdata[LIVE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_TICK) begin
            if (time_r != TIME_MAX) begin
              time_nxt = time_r + TIME_WIDTH'(1);
            end
          end else begin
            org_nxt         = in_origin;
            seq_nxt         = in_sequence_number;
            n_nxt           = n_cfg;
            exp_nxt         = exp_sum[TIME_WIDTH] ? TIME_MAX : exp_sum[TIME_WIDTH-1:0];
            scan_addr_nxt   = '0;
            match_found_nxt = 1'b0;
            free_found_nxt  = 1'b0;
            live_cnt_nxt    = '0;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle; data for rd_idx_r lands in the next cycle
        if (scan_addr_r < n_r) begin
          rd_pend_nxt   = 1'b1;
          rd_idx_nxt    = scan_addr_r[ADDR_W-1:0];
          scan_addr_nxt = scan_addr_r + CNT_W'(1);
        end else if (!rd_pend_r) begin
          state_nxt = ST_FINISH;
        end
        if (rd_pend_r) begin
          if (rd_live) begin
            live_cnt_nxt = live_cnt_r + CNT_W'(1);
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = rd_idx_r;
          end
          if (rd_match && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_slot_nxt  = rd_idx_r;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_is_new_nxt = !match_found_r;
          out_slot_nxt   = SLOT_W'(fin_slot);
          out_live_nxt   = LIVE_W'(fin_live);
          state_nxt      = ST_IDLE;
          if (!match_found_r) begin
            mem_we    = 1'b1;
            mem_waddr = fin_slot;
            mem_wdata = '{valid: 1'b1, origin: org_r, seq_num: seq_r, expiry: exp_r};
            ptr_nxt   = (slot_inc == n_r) ? '0 : slot_inc[ADDR_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ptr_r       <= '0;
      time_r      <= '0;
      lifetime_r  <= LIFETIME_RST;
      entries_r   <= ENTRIES_RST;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      scan_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ptr_r       <= ptr_nxt;
      time_r      <= time_nxt;
      lifetime_r  <= lifetime_nxt;
      entries_r   <= entries_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      scan_addr_r <= scan_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    org_r         <= org_nxt;
    seq_r         <= seq_nxt;
    n_r           <= n_nxt;
    exp_r         <= exp_nxt;
    rd_idx_r      <= rd_idx_nxt;
    match_found_r <= match_found_nxt;
    match_slot_r  <= match_slot_nxt;
    free_found_r  <= free_found_nxt;
    free_slot_r   <= free_slot_nxt;
    live_cnt_r    <= live_cnt_nxt;
    out_is_new_r  <= out_is_new_nxt;
    out_slot_r    <= out_slot_nxt;
    out_live_r    <= out_live_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/dpf_checker.sv
// ----------------------------------------------------------------------------
// dpf_checker
// Port-level properties of the duplicate packet filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "duplicate_packet_filter_top_macros.svh"

module dpf_checker import dpf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_opcode,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_is_new,
  input wire logic [SLOT_W-1:0] out_slot,
  input wire logic [LIVE_W-1:0] out_live_entries
);

  // a held result keeps its slot
  `DPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot))

  // a taken check item keeps the block busy, so in_ready drops after it
  `DPF_ASSERT_NEXT(a_check_busy, in_valid && in_ready && (in_opcode == OP_CHECK), !in_ready)

  // a duplicate hit a live entry, so the live count cannot be zero
  `DPF_ASSERT_NOW(a_dup_live, out_valid && !out_is_new, out_live_entries != '0)

  // reset starts the clearing pass with no item taken and no result shown
  `DPF_ASSERT_RST(a_rst_quiet, !rst_n, !in_ready && !out_valid)

endmodule

bind duplicate_packet_filter_top dpf_checker u_dpf_checker (.*);

`default_nettype wire
